[rtl/lprc_pkg.sv]
// ----------------------------------------------------------------------------
// lprc_pkg
// Shared types and codes for the counter-based LRU page replacer.
// ----------------------------------------------------------------------------
package lprc_pkg;

  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_FILL    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;
  localparam logic [1:0] OUT_REJECT  = 2'd3;

  localparam int CFG_BITS    = 4;
  localparam int OUT_PAGE_W  = 16;
  localparam int OUT_FRAME_W = 3;
  localparam int HIT_W       = 32;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0]             outcome;
    logic [OUT_FRAME_W-1:0] frame_index;
    logic [OUT_PAGE_W-1:0]  evicted_page;
    logic [HIT_W-1:0]       hit_count;
  } result_t;

endpackage

[rtl/lprc_ram.sv]
// ----------------------------------------------------------------------------
// lprc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lprc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/lprc_engine.sv]
// ----------------------------------------------------------------------------
// lprc_engine
// Sequencer: scans the frame table for hit, empty and oldest frame, then
// sweeps it to age frames and install the page; first access skips the scan.
// ----------------------------------------------------------------------------
module lprc_engine #(
  parameter int FRAMES    = 8,
  parameter int AGE_BITS  = 32,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int CNT_W     = $clog2(FRAMES + 1),
  parameter int ENT_W     = PAGE_BITS + AGE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PAGE_BITS-1:0]  page_in,
  input  logic [CNT_W-1:0]      n,
  input  logic                  take,
  output logic                  idle,
  output logic                  done,
  output lprc_pkg::result_t     result,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [ENT_W-1:0]      rd_data,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [ENT_W-1:0]      wr_data
);

  lprc_pkg::state_t state;

  logic                  started;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  dq_v;
  logic [IDX_W-1:0]      dq_idx;
  logic                  vbit_q;
  logic [FRAMES-1:0]     ent_vld;
  logic                  hit_found;
  logic                  empty_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      emp_idx;
  logic [IDX_W-1:0]      best_idx;
  logic [AGE_BITS-1:0]   best_age;
  logic [PAGE_BITS-1:0]  best_page;
  logic [IDX_W-1:0]      sel;
  logic                  first_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [lprc_pkg::HIT_W-1:0] hits;
  logic [1:0]            res_outcome;
  logic [PAGE_BITS-1:0]  res_evicted;

  logic [PAGE_BITS-1:0]  ent_page;
  logic [AGE_BITS-1:0]   ent_age;
  logic [AGE_BITS-1:0]   ent_age_up;
  logic                  last_data;
  logic                  sweep;

  assign sweep   = (state == lprc_pkg::ST_SCAN) || (state == lprc_pkg::ST_UPDATE);
  assign rd_en   = sweep && (rd_cnt < n);
  assign rd_addr = rd_cnt[IDX_W-1:0];

  assign ent_page   = vbit_q ? rd_data[ENT_W-1 -: PAGE_BITS] : '0;
  assign ent_age    = vbit_q ? rd_data[AGE_BITS-1:0] : '0;
  assign ent_age_up = (&ent_age) ? ent_age : ent_age + AGE_BITS'(1);
  assign last_data  = dq_v && (CNT_W'(dq_idx) == n - CNT_W'(1));

  // write-back sweep
  always_comb begin
    wr_en   = (state == lprc_pkg::ST_UPDATE) && dq_v;
    wr_addr = dq_idx;
    if (dq_idx == sel) begin
      wr_data = {page_q, AGE_BITS'(0)};
    end else if (first_q) begin
      wr_data = {PAGE_BITS'(0), AGE_BITS'(1)};
    end else begin
      wr_data = {ent_page, ent_age_up};
    end
  end

  assign idle = (state == lprc_pkg::ST_IDLE);
  assign done = (state == lprc_pkg::ST_DONE);

  always_comb begin
    result.outcome      = res_outcome;
    result.frame_index  = lprc_pkg::OUT_FRAME_W'(sel);
    result.evicted_page = lprc_pkg::OUT_PAGE_W'(res_evicted);
    result.hit_count    = hits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lprc_pkg::ST_IDLE;
      started <= 1'b0;
      rd_cnt  <= '0;
      dq_v    <= 1'b0;
      ent_vld <= '0;
      hits    <= '0;
    end else begin
      dq_v <= rd_en;
      if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
        dq_idx <= rd_addr;
        vbit_q <= ent_vld[rd_addr];
      end
      unique case (state)
        lprc_pkg::ST_IDLE: begin
          if (start) begin
            page_q      <= page_in;
            rd_cnt      <= '0;
            hit_found   <= 1'b0;
            empty_found <= 1'b0;
            first_q     <= 1'b0;
            res_evicted <= '0;
            if (page_in == '0) begin
              res_outcome <= lprc_pkg::OUT_REJECT;
              sel         <= '0;
              state       <= lprc_pkg::ST_DONE;
            end else if (!started) begin
              started     <= 1'b1;
              first_q     <= 1'b1;
              res_outcome <= lprc_pkg::OUT_FILL;
              sel         <= '0;
              state       <= lprc_pkg::ST_UPDATE;
            end else begin
              state <= lprc_pkg::ST_SCAN;
            end
          end
        end
        lprc_pkg::ST_SCAN: begin
          if (dq_v) begin
            if (!hit_found && ent_page == page_q) begin
              hit_found <= 1'b1;
              hit_idx   <= dq_idx;
            end
            if (!empty_found && ent_page == '0) begin
              empty_found <= 1'b1;
              emp_idx     <= dq_idx;
            end
            if (dq_idx == '0 || ent_age > best_age) begin
              best_age  <= ent_age;
              best_idx  <= dq_idx;
              best_page <= ent_page;
            end
          end
          if (last_data) begin
            state <= lprc_pkg::ST_DECIDE;
          end
        end
        lprc_pkg::ST_DECIDE: begin
          rd_cnt <= '0;
          if (hit_found) begin
            sel         <= hit_idx;
            res_outcome <= lprc_pkg::OUT_HIT;
            if (hits != '1) begin
              hits <= hits + lprc_pkg::HIT_W'(1);
            end
          end else if (empty_found) begin
            sel         <= emp_idx;
            res_outcome <= lprc_pkg::OUT_FILL;
          end else begin
            sel         <= best_idx;
            res_outcome <= lprc_pkg::OUT_REPLACE;
            res_evicted <= best_page;
          end
          state <= lprc_pkg::ST_UPDATE;
        end
        lprc_pkg::ST_UPDATE: begin
          if (wr_en) begin
            ent_vld[dq_idx] <= 1'b1;
          end
          if (last_data) begin
            state <= lprc_pkg::ST_DONE;
          end
        end
        lprc_pkg::ST_DONE: begin
          if (take) begin
            state <= lprc_pkg::ST_IDLE;
          end
        end
        default: state <= lprc_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/lru_page_replacer_counters.sv]
// ----------------------------------------------------------------------------
// lru_page_replacer_counters
// Counter-based LRU page replacement over a table of page frames held in RAM.
// ----------------------------------------------------------------------------
//  channel        signals                                    dir
//  page access    page_valid, page_ready, page_number        in
//  result         result_valid, result_ready, outcome,       out
//                 frame_index, evicted_page, hit_count
//  config         frames_in_use_we, frames_in_use            in
//
//  Per access, n the managed frame count: a search sweep of the frame RAM,
//  a decision state, an ageing write-back sweep and hand-over; the first
//  access skips the search; a zero page is rejected without a sweep.
//  A new page is taken once the last result is registered, not before.
//  Reset clears control state; valid flags on the frame entries stand in for
//  a RAM clearing pass. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module lru_page_replacer_counters #(
  parameter int FRAMES    = 8,
  parameter int AGE_BITS  = 32,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        frames_in_use_we,
  input  logic [3:0]  frames_in_use,
  input  logic        page_valid,
  output logic        page_ready,
  input  logic [15:0] page_number,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  outcome,
  output logic [2:0]  frame_index,
  output logic [15:0] evicted_page,
  output logic [31:0] hit_count
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int ENT_W = PAGE_BITS + AGE_BITS;

  logic [lprc_pkg::CFG_BITS-1:0] frames_cfg;
  logic [CNT_W-1:0]              n;
  logic                          idle;
  logic                          done;
  logic                          take;
  lprc_pkg::result_t             res;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [ENT_W-1:0]              rd_data;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [ENT_W-1:0]              wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= lprc_pkg::CFG_RESET;
    end else if (frames_in_use_we) begin
      frames_cfg <= frames_in_use;
    end
  end

  always_comb begin
    if (frames_cfg == '0) begin
      n = CNT_W'(1);
    end else if (32'(frames_cfg) > FRAMES) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(frames_cfg);
    end
  end

  assign page_ready = idle;
  assign take       = !result_valid || result_ready;

  lprc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lprc_engine #(
    .FRAMES    (FRAMES),
    .AGE_BITS  (AGE_BITS),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (page_valid && page_ready),
    .page_in (PAGE_BITS'(page_number)),
    .n       (n),
    .take    (take),
    .idle    (idle),
    .done    (done),
    .result  (res),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (take && done) begin
      outcome      <= res.outcome;
      frame_index  <= res.frame_index;
      evicted_page <= res.evicted_page;
      hit_count    <= res.hit_count;
    end
  end

endmodule
